/* rtl/core/tghs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain grid height sampler package
// Shared transaction types, codes and constants of the height sampler.
// ----------------------------------------------------------------------------
package tghs_pkg;

	localparam int GRID_VERTS_DEF = 4096;

	// Request types.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_LOADED  = 2'd0;
	localparam logic [1:0] STAT_ANSWER  = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COLUMNS = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_SPACING = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic [11:0]        vertex_slot;
		logic signed [23:0] vertex_height;
		logic [23:0]        query_x;
		logic [23:0]        query_z;
	} tghs_req_t;

	typedef struct packed {
		logic signed [23:0] surface_height;
		logic [1:0]         status;
	} tghs_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVPOS,
		ST_ADDR,
		ST_CHECK,
		ST_READ,
		ST_MUL,
		ST_SUM,
		ST_QDIV,
		ST_FIN,
		ST_OUT
	} tghs_state_t;

endpackage

/* rtl/core/terrain_grid_height_sample.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain grid height sampler
// Holds vertex heights of a regular grid and answers interpolated heights.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | tghs_req_t (load or query)
//  rsp     | out       | rsp_valid/rsp_stall  | tghs_rsp_t (height, status)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// A load goes from the request buffer through ST_IDLE, where a slot that fits
// the memory is written, and ST_OUT to the result register. A query runs the
// cell division of x and z, the bounds checks, the four corner reads on the
// single memory port, the products and the rounding division of the
// interpolation numerator. A query whose cell lies outside ends at a bounds check.
// A request is buffered while the previous one is still worked on, and a
// finished result waits in the output register while the next one runs.
// Reset clears the control state and restores the register defaults; the
// height memory is not cleared and holds garbage until written.
//
module terrain_grid_height_sample
	import tghs_pkg::*;
#(
	parameter int GRID_VERTS = GRID_VERTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  tghs_req_t   req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output tghs_rsp_t   rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(GRID_VERTS);
	localparam logic [31:0] GV = 32'(GRID_VERTS);

	// Configuration registers.
	logic [12:0] columns_q, rows_q;
	logic [9:0]  spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 13'd64;
			rows_q    <= 13'd64;
			spacing_q <= 10'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMNS: columns_q <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data;
				CFG_SPACING: spacing_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// A spacing of zero behaves as one.
	logic [9:0]  sp_eff;
	logic [17:0] span;
	logic [18:0] span2;
	assign sp_eff = (spacing_q == 10'd0) ? 10'd1 : spacing_q;
	assign span   = {sp_eff, 8'd0};
	assign span2  = {sp_eff, 9'd0};

	// Request buffer: one transaction waits here while the sequencer is busy.
	tghs_req_t buf_q;
	logic      buf_v_q;
	logic      req_take;
	logic      buf_take;

	assign req_stall = buf_v_q;
	assign req_take  = req_valid && !req_stall;

	tghs_state_t cur_q, nxt;

	// Cell division of x and z by the spacing, one quotient bit per cycle.
	logic [15:0] dvx_q, dvz_q;
	logic [9:0]  remx_q, remz_q;
	logic [7:0]  xf_q, zf_q;
	logic [5:0]  step_q;
	logic [10:0] tx, tz;
	logic        gex, gez;

	assign tx  = {remx_q, dvx_q[15]};
	assign tz  = {remz_q, dvz_q[15]};
	assign gex = tx >= {1'b0, sp_eff};
	assign gez = tz >= {1'b0, sp_eff};

	// Bounds check of the cell.
	logic        outside_cell;
	assign outside_cell = ({1'b0, dvx_q} + 17'd1 >= {4'd0, columns_q}) ||
	                      ({1'b0, dvz_q} + 17'd1 >= {4'd0, rows_q});

	logic [28:0] rowbase_q;
	logic [15:0] col_q;
	logic [17:0] rx_q, fzn_q;
	logic [31:0] bl_full, tr_full;
	logic        outside_store;

	assign bl_full = {3'd0, rowbase_q} + {16'd0, col_q};
	assign tr_full = bl_full + {19'd0, columns_q} + 32'd1;
	assign outside_store = tr_full >= GV;

	logic [AW-1:0] tl_a_q, tr_a_q, bl_a_q, br_a_q;

	// Corner reads: tl, tr, bl, br in that order.
	logic [2:0]         rd_q;
	logic signed [23:0] h_q [4];

	// Height memory, one read or write per cycle, registered read data.
	logic [23:0]   mem [GRID_VERTS];
	logic [23:0]   rdata_q;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic          load_ok;

	assign load_ok = {20'd0, buf_q.vertex_slot} < GV;

	always_comb begin
		case (rd_q[1:0])
			2'd0:    mem_addr = tl_a_q;
			2'd1:    mem_addr = tr_a_q;
			2'd2:    mem_addr = bl_a_q;
			default: mem_addr = br_a_q;
		endcase
		if (mem_we) begin
			mem_addr = AW'(buf_q.vertex_slot);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= buf_q.vertex_height;
		end
		rdata_q <= mem[mem_addr];
	end

	// Interpolation on the chosen triangle.
	logic               upper;
	logic signed [24:0] d_a, d_b;
	logic signed [43:0] pa_q, pb_q;
	logic signed [46:0] numer;

	assign upper = rx_q > fzn_q;
	always_comb begin
		if (upper) begin
			d_a = 25'(h_q[1]) - 25'(h_q[0]);
			d_b = 25'(h_q[3]) - 25'(h_q[1]);
		end else begin
			d_a = 25'(h_q[3]) - 25'(h_q[2]);
			d_b = 25'(h_q[2]) - 25'(h_q[0]);
		end
	end

	// 2*num + S, to be floor-divided by 2*S.
	assign numer = ((47'(pa_q) + 47'(pb_q)) <<< 1) + $signed({29'd0, span});

	// Rounding division, one quotient bit per cycle on the magnitude.
	logic [45:0] nd_q;
	logic [18:0] rq_q;
	logic        neg_q;
	logic [19:0] tq;
	logic        geq;

	assign tq  = {rq_q, nd_q[45]};
	assign geq = tq >= {1'b0, span2};

	logic [46:0]        qmag;
	logic signed [47:0] qs, ysum;
	logic signed [23:0] ysat;

	assign qmag = {1'b0, nd_q} + {46'd0, neg_q && (rq_q != 19'd0)};
	assign qs   = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	assign ysum = qs + 48'(h_q[0]);
	always_comb begin
		if (ysum > 48'sd8388607) begin
			ysat = 24'sh7FFFFF;
		end else if (ysum < -48'sd8388608) begin
			ysat = 24'sh800000;
		end else begin
			ysat = ysum[23:0];
		end
	end

	// Result waiting for the output register.
	tghs_rsp_t res_q;
	logic      out_free;
	logic      out_load;

	assign out_free = !rsp_valid || !rsp_stall;

	// Next state.
	always_comb begin
		nxt = cur_q;
		unique case (cur_q)
			ST_IDLE: begin
				if (buf_v_q) begin
					nxt = (buf_q.req_type == REQ_LOAD) ? ST_OUT : ST_DIVPOS;
				end
			end
			ST_DIVPOS: if (step_q == 6'd15) nxt = ST_ADDR;
			ST_ADDR:   nxt = outside_cell ? ST_OUT : ST_CHECK;
			ST_CHECK:  nxt = outside_store ? ST_OUT : ST_READ;
			ST_READ:   if (rd_q == 3'd4) nxt = ST_MUL;
			ST_MUL:    nxt = ST_SUM;
			ST_SUM:    nxt = ST_QDIV;
			ST_QDIV:   if (step_q == 6'd45) nxt = ST_FIN;
			ST_FIN:    nxt = ST_OUT;
			ST_OUT:    if (out_free) nxt = ST_IDLE;
			default:   nxt = ST_IDLE;
		endcase
	end

	// Control strobes.
	always_comb begin
		buf_take = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		unique case (cur_q)
			ST_IDLE: begin
				buf_take = buf_v_q;
				mem_we   = buf_v_q && (buf_q.req_type == REQ_LOAD) && load_ok;
			end
			ST_OUT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= ST_IDLE;
			buf_v_q   <= 1'b0;
			rsp_valid <= 1'b0;
			step_q    <= '0;
			rd_q      <= '0;
		end else begin
			cur_q <= nxt;
			if (req_take) begin
				buf_v_q <= 1'b1;
			end else if (buf_take) begin
				buf_v_q <= 1'b0;
			end
			if (out_load) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (cur_q == ST_DIVPOS || cur_q == ST_QDIV) begin
				step_q <= (nxt == cur_q) ? step_q + 6'd1 : 6'd0;
			end else begin
				step_q <= '0;
			end
			rd_q <= (cur_q == ST_READ && rd_q != 3'd4) ? rd_q + 3'd1 : 3'd0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_take) begin
			buf_q <= req;
		end
		if (out_load) begin
			rsp <= res_q;
		end
		unique case (cur_q)
			ST_IDLE: begin
				dvx_q  <= buf_q.query_x[23:8];
				dvz_q  <= buf_q.query_z[23:8];
				xf_q   <= buf_q.query_x[7:0];
				zf_q   <= buf_q.query_z[7:0];
				remx_q <= '0;
				remz_q <= '0;
				res_q.surface_height <= '0;
				res_q.status <= load_ok ? STAT_LOADED : STAT_OUTSIDE;
			end
			ST_DIVPOS: begin
				dvx_q  <= {dvx_q[14:0], gex};
				dvz_q  <= {dvz_q[14:0], gez};
				remx_q <= gex ? 10'(tx - {1'b0, sp_eff}) : tx[9:0];
				remz_q <= gez ? 10'(tz - {1'b0, sp_eff}) : tz[9:0];
			end
			ST_ADDR: begin
				rowbase_q <= dvz_q * columns_q;
				col_q     <= dvx_q;
				rx_q      <= {remx_q, xf_q};
				fzn_q     <= span - {remz_q, zf_q};
				res_q.surface_height <= '0;
				res_q.status <= STAT_OUTSIDE;
			end
			ST_CHECK: begin
				bl_a_q <= bl_full[AW-1:0];
				br_a_q <= AW'(bl_full + 32'd1);
				tl_a_q <= AW'(bl_full + {19'd0, columns_q});
				tr_a_q <= tr_full[AW-1:0];
			end
			ST_READ: begin
				if (rd_q != 3'd0) begin
					h_q[2'(rd_q - 3'd1)] <= rdata_q;
				end
			end
			ST_MUL: begin
				pa_q <= $signed({1'b0, rx_q}) * d_a;
				pb_q <= $signed({1'b0, fzn_q}) * d_b;
			end
			ST_SUM: begin
				neg_q <= numer[46];
				nd_q  <= numer[46] ? 46'(-numer) : numer[45:0];
				rq_q  <= '0;
			end
			ST_QDIV: begin
				nd_q <= {nd_q[44:0], geq};
				rq_q <= geq ? 19'(tq - {1'b0, span2}) : tq[18:0];
			end
			ST_FIN: begin
				res_q.surface_height <= ysat;
				res_q.status <= STAT_ANSWER;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// The memory is written only while a load is taken from the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cur_q == ST_IDLE && buf_v_q && buf_q.req_type == REQ_LOAD))
		else $error("height memory written outside a load");

	// A waiting result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !out_load)
		else $error("stalled result overwritten");

	// The corner read counter stays within its four reads.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= 3'd4)
		else $error("corner read counter out of range");

	// A result is always one of the three status codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status != 2'd3))
		else $error("invalid status code");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain grid height sampler testbench
// Loads vertex heights and sends height queries through the request channel.
// Every accepted transaction is predicted by a software copy of the grid, and
// every response is compared in order with the oldest predicted response.
// The run goes through several grid settings, directed ones first, random ones last.
// ----------------------------------------------------------------------------
module tb_top;
	import tghs_pkg::*;

	localparam int STORE_DEPTH = GRID_VERTS_DEF;
	localparam longint H_MAX = 64'sd8388607;
	localparam longint H_MIN = -64'sd8388608;

	// The grid model keeps its own copy of the heights and the registers, so
	// the expected response of each transaction is known when it is accepted.
	class grid_scoreboard;
		logic signed [23:0] heights [STORE_DEPTH];
		bit                 loaded [STORE_DEPTH];
		int unsigned        columns = 64;
		int unsigned        rows = 64;
		int unsigned        spacing = 1;
		tghs_rsp_t          pending_results [$];
		int                 errors = 0;
		int                 n_loads = 0;
		int                 n_answers = 0;
		int                 n_outside = 0;

		function void set_register(logic [1:0] idx, logic [12:0] val);
			case (idx)
				CFG_COLUMNS: columns = val;
				CFG_ROWS:    rows = val;
				CFG_SPACING: spacing = val[9:0];
				default: ;
			endcase
		endfunction

		// Finds the cell of a position; returns 0 when the cell lies outside
		// the grid or its top-right corner falls beyond the height store.
		function bit locate_cell(logic [23:0] x, logic [23:0] z, output longint bl,
				output longint rx, output longint fzn, output longint s);
			longint col, row;
			s = (spacing == 0 ? 1 : spacing) * 256;
			col = longint'(x) / s;
			row = longint'(z) / s;
			rx = longint'(x) - col * s;
			fzn = s - (longint'(z) - row * s);
			bl = row * columns + col;
			if (col + 1 >= columns || row + 1 >= rows)
				return 0;
			return (bl + columns + 1) < STORE_DEPTH;
		endfunction

		function tghs_rsp_t height_at(tghs_req_t r);
			tghs_rsp_t res;
			longint bl, rx, fzn, s, hbl, hbr, htl, htr, num, n, d, q, y;
			res.surface_height = '0;
			if (r.req_type == REQ_LOAD) begin
				heights[r.vertex_slot] = r.vertex_height;
				loaded[r.vertex_slot] = 1;
				res.status = STAT_LOADED;
				return res;
			end
			if (!locate_cell(r.query_x, r.query_z, bl, rx, fzn, s)) begin
				res.status = STAT_OUTSIDE;
				return res;
			end
			hbl = heights[bl];
			hbr = heights[bl + 1];
			htl = heights[bl + columns];
			htr = heights[bl + columns + 1];
			// The triangle is picked by an exact compare of the two fractions.
			if (rx > fzn)
				num = rx * (htr - htl) + fzn * (hbr - htr);
			else
				num = rx * (hbr - hbl) + fzn * (hbl - htl);
			// Round to nearest with ties upward, as a floor of (2n+s)/2s.
			n = 2 * num + s;
			d = 2 * s;
			q = n / d;
			if (n % d != 0 && n < 0)
				q = q - 1;
			y = htl + q;
			if (y > H_MAX)
				y = H_MAX;
			if (y < H_MIN)
				y = H_MIN;
			res.surface_height = y[23:0];
			res.status = STAT_ANSWER;
			return res;
		endfunction

		function void note_request(tghs_req_t r);
			tghs_rsp_t res;
			res = height_at(r);
			pending_results.push_back(res);
			if (res.status == STAT_LOADED)
				n_loads++;
			else if (res.status == STAT_ANSWER)
				n_answers++;
			else
				n_outside++;
		endfunction

		function void check_response(tghs_rsp_t got);
			tghs_rsp_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response height=%0d status=%0d", $realtime,
					got.surface_height, got.status);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch expected=%0d actual=%0d", $realtime,
					want.status, got.status);
				errors++;
			end
			if (got.surface_height !== want.surface_height) begin
				$display("%0t: height mismatch expected=%0d actual=%0d", $realtime,
					want.surface_height, got.surface_height);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	tghs_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	tghs_rsp_t rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_COLUMNS;
	logic [12:0] cfg_data = '0;

	grid_scoreboard grid = new();

	// Flags shared between the stimulus processes, and the count of grid settings.
	bit hold_request = 0;
	bit quiet_mode = 0;
	int n_settings = 0;

	always #5 clk = ~clk;

	terrain_grid_height_sample u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Response monitor: a transaction leaves the block on an edge with valid
	// high and stall low, both seen as they were before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			grid.check_response(rsp);
	end

	// Quiet stretches with no idling alternate with noisy ones.
	initial begin
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			quiet_mode = ($urandom_range(0, 3) == 0);
		end
	end

	// Receiver back-pressure. A long hold, when requested, lets the block
	// fill up so that it has to stall its request channel.
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_request = 0;
				rsp_stall <= 1'b0;
			end else if (quiet_mode) begin
				rsp_stall <= 1'b0;
			end else begin
				k = $urandom_range(0, 99);
				if (k < 3) begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(10, 50)) @(posedge clk);
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= (k < 30);
				end
			end
		end
	end

	function int pick_gap();
		int k;
		if (quiet_mode)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function logic signed [23:0] pick_height();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(0, 15) - 8);
			default: return 24'($urandom);
		endcase
	endfunction

	// Offers one transaction and returns once it has been accepted. Valid
	// stays high after acceptance so back-to-back transactions need no gap.
	task automatic send_request(tghs_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		grid.note_request(r);
	endtask

	task automatic send_load(logic [11:0] slot, logic signed [23:0] h);
		tghs_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom};
		r.req_type = REQ_LOAD;
		r.vertex_slot = slot;
		r.vertex_height = h;
		send_request(r);
	endtask

	// A query into a cell inside the grid first loads whichever of its four
	// corners has never been written, so no unwritten height is ever read.
	task automatic send_query(logic [23:0] x, logic [23:0] z);
		tghs_req_t r;
		longint bl, rx, fzn, s;
		longint corners [4];
		if (grid.locate_cell(x, z, bl, rx, fzn, s)) begin
			corners = '{bl, bl + 1, bl + grid.columns, bl + grid.columns + 1};
			foreach (corners[i])
				if (!grid.loaded[corners[i]])
					send_load(corners[i], pick_height());
		end
		r = {$urandom, $urandom, $urandom, $urandom};
		r.req_type = REQ_QUERY;
		r.query_x = x;
		r.query_z = z;
		send_request(r);
	endtask

	// Picks a position inside a valid cell when one exists, with the offsets
	// biased toward the cell edges and the diagonal where the triangles meet.
	task automatic send_cell_query();
		longint s, colmax, rowmax, col, row, rx, rz;
		s = (grid.spacing == 0 ? 1 : grid.spacing) * 256;
		colmax = grid.columns - 2;
		rowmax = grid.rows - 2;
		if (colmax > 24'hFFFFFF / s)
			colmax = 24'hFFFFFF / s;
		if (rowmax > 24'hFFFFFF / s)
			rowmax = 24'hFFFFFF / s;
		if (grid.columns < 2 || grid.rows < 2 || grid.columns + 1 >= STORE_DEPTH) begin
			send_query($urandom, $urandom);
			return;
		end
		row = $urandom_range(0, rowmax);
		col = $urandom_range(0, colmax);
		if ((row + 1) * grid.columns + col + 1 >= STORE_DEPTH) begin
			row = 0;
			col = 0;
		end
		case ($urandom_range(0, 5))
			0: begin rx = 0; rz = 0; end
			1: begin rx = s - 1; rz = s - 1; end
			2: begin rx = $urandom_range(1, s - 1); rz = s - rx; end
			default: begin rx = $urandom_range(0, s - 1); rz = $urandom_range(0, s - 1); end
		endcase
		if (col * s + rx > 24'hFFFFFF)
			rx = 24'hFFFFFF - col * s;
		if (row * s + rz > 24'hFFFFFF)
			rz = 24'hFFFFFF - row * s;
		send_query(col * s + rx, row * s + rz);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (grid.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid.set_register(idx, val);
	endtask

	task automatic set_grid(logic [12:0] cols, logic [12:0] nrows, logic [12:0] sp);
		wait_idle();
		write_register(CFG_COLUMNS, cols);
		write_register(CFG_ROWS, nrows);
		write_register(CFG_SPACING, sp);
		n_settings++;
	endtask

	task automatic run_random(int count);
		int k;
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (k < 20)
				send_load($urandom, pick_height());
			else if (k < 85)
				send_cell_query();
			else
				send_query($urandom, $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset grid: extreme heights around the first
		// cell, both triangles, the diagonal tie, the far cell edge and a
		// position beyond the last row and column.
		set_grid(13'd64, 13'd64, 13'd1);
		send_load(12'd0, 24'sh7FFFFF);
		send_load(12'd1, 24'sh800000);
		send_load(12'd64, 24'sh800000);
		send_load(12'd65, 24'sh7FFFFF);
		send_load(12'd4095, 24'sh000101);
		send_query(24'd0, 24'd0);
		send_query(24'd255, 24'd255);
		send_query(24'd128, 24'd128);
		send_query(24'd200, 24'd10);
		send_query(24'd10, 24'd200);
		send_query(24'd129, 24'd128);
		send_query(24'd63 * 256, 24'd0);
		send_query(24'd0, 24'd63 * 256);
		send_query(24'hFFFFFF, 24'hFFFFFF);
		send_query(24'd62 * 256 + 255, 24'd62 * 256 + 255);

		// Smallest grid at the widest spacing.
		set_grid(13'd2, 13'd2, 13'd1023);
		send_query(24'd0, 24'd0);
		send_query(24'd261887, 24'd261887);
		run_random(40);

		// A zero spacing behaves as one; upper spacing bits are dropped.
		set_grid(13'd8, 13'd8, 13'd0);
		run_random(40);
		set_grid(13'd8, 13'd9, 13'h1405);
		run_random(30);

		// Grids too small or too large for any query to be answered.
		set_grid(13'd1, 13'd5, 13'd3);
		run_random(15);
		set_grid(13'd5, 13'd0, 13'd3);
		run_random(15);
		set_grid(13'd8191, 13'd8191, 13'd7);
		run_random(20);
		set_grid(13'd4096, 13'd4096, 13'd1);
		run_random(20);

		// Wide and tall grids that still fit the store.
		set_grid(13'd4094, 13'd2, 13'd2);
		run_random(40);
		set_grid(13'd2, 13'd2048, 13'd1);
		run_random(20);

		// The receiver holds off while queries keep coming.
		set_grid(13'd16, 13'd16, 13'd4);
		hold_request = 1;
		run_random(40);

		repeat (2) begin
			set_grid($urandom_range(2, 100), $urandom_range(2, 100), $urandom_range(1, 1023));
			run_random(15);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		$display("Covered %0d loads, %0d answered and %0d outside-grid transactions",
			grid.n_loads, grid.n_answers, grid.n_outside);
		$display("over %0d grid settings, with %0d responses still pending.", n_settings,
			grid.pending_results.size());
		if (grid.errors == 0 && grid.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

/* terrain_grid_height_sample.f */
rtl/core/tghs_pkg.sv
rtl/core/terrain_grid_height_sample.sv
dv/tb_top.sv
